@@ hw/rtl/aliquot_sum_trial_division_core_defines.svh @@
// Assertion macros for the aliquot sum core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef ALIQUOT_SUM_TRIAL_DIVISION_CORE_DEFINES_SVH
`define ALIQUOT_SUM_TRIAL_DIVISION_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define ASTD_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("astd assertion failed");
// property checked on every clock edge, reset included
`define ASTD_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("astd assertion failed");
`else
`define ASTD_ASSERT(name, clk, rst_n, prop)
`define ASTD_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

@@ hw/rtl/astd_pkg.sv @@
// Package for the aliquot sum core: widths and limits.
// No dependencies.
`timescale 1ns / 1ps

package astd_pkg;

	// width of the input number
	localparam int NUMBER_BITS = 20;
	// width of the result
	localparam int SUM_BITS = 23;
	// trial divisor width: holds the first candidate whose square exceeds any number
	localparam int CAND_BITS = (NUMBER_BITS + 1) / 2 + 1;
	// running square of the candidate
	localparam int SQ_BITS = 2 * CAND_BITS;
	// divider step counter
	localparam int STEP_BITS = $clog2(NUMBER_BITS);
	// sum before saturation, wide enough for accumulator plus both divisors
	localparam int WIDE_BITS = ((SUM_BITS > NUMBER_BITS) ? SUM_BITS : NUMBER_BITS) + 2;
	// largest result value
	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

endpackage

@@ hw/rtl/aliquot_sum_trial_division_core.sv @@
// Aliquot sum core: sum of proper divisors by trial division with a shared radix-2 divider.
// Depends on astd_pkg and aliquot_sum_trial_division_core_defines.svh.
//
//   channel   ports                      handshake
//   -------   ------------------------   ------------------------------------
//   request   start, number              taken when start is high, busy low
//   result    done, divisor_sum          one-cycle strobe, cannot be held off
//
// Each candidate from 2 while cand*cand <= number goes through one square compare,
// NUMBER_BITS restoring-division steps on the shared subtractor and one accumulate step.
// busy stays high from the accepted request until the cycle done is shown.
// Reset clears the sequencer and the done strobe; no clearing pass is needed.
`timescale 1ns / 1ps
`include "aliquot_sum_trial_division_core_defines.svh"

module aliquot_sum_trial_division_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [astd_pkg::NUMBER_BITS-1:0]  number,
	output logic                              done,
	output logic [astd_pkg::SUM_BITS-1:0]     divisor_sum
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_ACC
	} state_t;

	state_t                              state_q;
	logic [astd_pkg::NUMBER_BITS-1:0]    num_q;
	logic [astd_pkg::CAND_BITS-1:0]      cand_q;
	logic [astd_pkg::SQ_BITS-1:0]        sq_q;
	logic [astd_pkg::NUMBER_BITS-1:0]    dvd_q;
	logic [astd_pkg::CAND_BITS-1:0]      rem_q;
	logic [astd_pkg::STEP_BITS-1:0]      step_q;
	logic [astd_pkg::SUM_BITS-1:0]       acc_q;
	logic                                done_q;
	logic [astd_pkg::SUM_BITS-1:0]       divisor_sum_q;

	logic [astd_pkg::CAND_BITS:0]        shifted;
	logic                                qbit;
	logic [astd_pkg::CAND_BITS:0]        rem_diff;
	logic [astd_pkg::NUMBER_BITS-1:0]    cand_ext;
	logic [astd_pkg::WIDE_BITS-1:0]      pair_add;
	logic [astd_pkg::WIDE_BITS-1:0]      sum_wide;
	logic [astd_pkg::SUM_BITS-1:0]       sum_sat;
	logic                                past_root;

	// one restoring division step on the shared subtractor
	always_comb begin
		shifted  = {rem_q, dvd_q[astd_pkg::NUMBER_BITS-1]};
		qbit     = (shifted >= {1'b0, cand_q});
		rem_diff = shifted - {1'b0, cand_q};
	end

	// divisor pair add with saturation, square root counted once
	always_comb begin
		cand_ext = astd_pkg::NUMBER_BITS'(cand_q);
		pair_add = astd_pkg::WIDE_BITS'(cand_q);
		if (dvd_q != cand_ext) begin
			pair_add = pair_add + astd_pkg::WIDE_BITS'(dvd_q);
		end
		sum_wide = astd_pkg::WIDE_BITS'(acc_q) + pair_add;
		if (sum_wide > astd_pkg::WIDE_BITS'(astd_pkg::SUM_MAX)) begin
			sum_sat = astd_pkg::SUM_MAX;
		end else begin
			sum_sat = sum_wide[astd_pkg::SUM_BITS-1:0];
		end
	end

	// loop ends once the candidate square passes the number
	assign past_root = (sq_q > astd_pkg::SQ_BITS'(num_q));

	// sequencer with registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						num_q   <= number;
						cand_q  <= astd_pkg::CAND_BITS'(2);
						sq_q    <= astd_pkg::SQ_BITS'(4);
						acc_q   <= (number >= astd_pkg::NUMBER_BITS'(2)) ?
							astd_pkg::SUM_BITS'(1) : '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (past_root) begin
						divisor_sum_q <= acc_q;
						done_q        <= 1'b1;
						state_q       <= ST_IDLE;
					end else begin
						dvd_q   <= num_q;
						rem_q   <= '0;
						step_q  <= astd_pkg::STEP_BITS'(astd_pkg::NUMBER_BITS - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (qbit) begin
						rem_q <= rem_diff[astd_pkg::CAND_BITS-1:0];
					end else begin
						rem_q <= shifted[astd_pkg::CAND_BITS-1:0];
					end
					dvd_q <= {dvd_q[astd_pkg::NUMBER_BITS-2:0], qbit};
					if (step_q == '0) begin
						state_q <= ST_ACC;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_ACC: begin
					if (rem_q == '0) begin
						acc_q <= sum_sat;
					end
					sq_q    <= sq_q + astd_pkg::SQ_BITS'({cand_q, 1'b1});
					cand_q  <= cand_q + 1'b1;
					state_q <= ST_CHECK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign divisor_sum = divisor_sum_q;

	// an accepted request makes the core busy on the next cycle
	`ASTD_ASSERT(a_start_busy, clk, arst_n, (start && !busy) |=> busy)
	// a result is only shown as the core leaves its work
	`ASTD_ASSERT(a_done_after_busy, clk, arst_n, done |-> (!busy && $past(busy)))
	// the divider remainder always stays below the candidate
	`ASTD_ASSERT(a_rem_bound, clk, arst_n, (state_q == ST_DIV) |-> (rem_q < cand_q))
	// candidates never fall below two while working
	`ASTD_ASSERT(a_cand_min, clk, arst_n, busy |-> (cand_q >= astd_pkg::CAND_BITS'(2)))
	// no result strobe while in reset
	`ASTD_ASSERT_ALWAYS(a_no_done_in_reset, clk, !arst_n |-> !done)

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for aliquot_sum_trial_division_core.
// One request in, one proper divisor sum out; depends on astd_pkg and the core RTL.
// The expected sums come from a trial-division predictor kept here.
`timescale 1ns / 1ps

module tb_top;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b1;
	logic                             start = 1'b0;
	logic                             busy;
	logic [astd_pkg::NUMBER_BITS-1:0] number = '0;
	logic                             done;
	logic [astd_pkg::SUM_BITS-1:0]    divisor_sum;

	// numbers waiting to be issued, and sums waiting to come back
	logic [astd_pkg::NUMBER_BITS-1:0] pending_numbers[$];
	logic [astd_pkg::SUM_BITS-1:0]    expected_sums[$];

	int requests_sent = 0;
	int requests_accepted = 0;
	int mismatch_count = 0;
	int burst_left = 0;
	int gap_left = 0;

	aliquot_sum_trial_division_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.number      (number),
		.done        (done),
		.divisor_sum (divisor_sum)
	);

	always #5 clk = ~clk;

	// sum of proper divisors by trial division, saturated to the result width
	function automatic logic [astd_pkg::SUM_BITS-1:0] proper_divisor_sum(
			logic [astd_pkg::NUMBER_BITS-1:0] value);
		bit [63:0] n;
		bit [63:0] total;
		bit [63:0] trial;
		bit [63:0] partner;
		n = value;
		if (n < 2)
			return '0;
		total = 1;
		for (trial = 2; trial * trial <= n; trial++) begin
			if (n % trial == 0) begin
				partner = n / trial;
				if (partner == trial)
					total += trial;
				else
					total += trial + partner;
			end
		end
		if (total > astd_pkg::SUM_MAX)
			total = astd_pkg::SUM_MAX;
		return total[astd_pkg::SUM_BITS-1:0];
	endfunction

	// random number: mostly small so runs stay short, some squares, a few full width
	function automatic logic [astd_pkg::NUMBER_BITS-1:0] random_number();
		int pick;
		int root;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return astd_pkg::NUMBER_BITS'($urandom_range(0, 4095));
		if (pick < 70) begin
			root = $urandom_range(1, 255);
			return astd_pkg::NUMBER_BITS'(root * root);
		end
		if (pick < 90)
			return astd_pkg::NUMBER_BITS'($urandom_range(0, 65535));
		return astd_pkg::NUMBER_BITS'($urandom);
	endfunction

	// request driver: bursts of back-to-back requests with random gaps in between
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && requests_accepted != requests_sent) begin
			// request still waiting for busy to drop
		end else if (gap_left > 0) begin
			start <= 1'b0;
			number <= astd_pkg::NUMBER_BITS'($urandom);
			gap_left <= gap_left - 1;
		end else if (pending_numbers.size() > 0) begin
			number <= pending_numbers.pop_front();
			start <= 1'b1;
			requests_sent <= requests_sent + 1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 8);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			start <= 1'b0;
			number <= astd_pkg::NUMBER_BITS'($urandom);
		end
	end

	// monitor: check the result strobe first, then record a newly taken request
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_sums.size() == 0) begin
					$error("divisor_sum: no result expected, actual %0d", divisor_sum);
					mismatch_count++;
				end else begin
					logic [astd_pkg::SUM_BITS-1:0] want;
					want = expected_sums.pop_front();
					if (divisor_sum !== want) begin
						$error("divisor_sum: expected %0d, actual %0d", want, divisor_sum);
						mismatch_count++;
					end
				end
			end
			if (start && !busy) begin
				expected_sums = {expected_sums, proper_divisor_sum(number)};
				requests_accepted <= requests_accepted + 1;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		// assert reset once every process waits on its edges
		arst_n <= 1'b0;

		// zero, one, primes, squares, perfect and amicable numbers, field extremes
		pending_numbers = '{
			20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd5, 20'd6, 20'd8, 20'd9, 20'd12,
			20'd16, 20'd25, 20'd28, 20'd36, 20'd49, 20'd220, 20'd284, 20'd496,
			20'd8128, 20'd720720, 20'd524288, 20'd1046529, 20'd1048573, 20'd1000000,
			20'd1048575
		};
		repeat (75)
			pending_numbers = {pending_numbers, random_number()};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_numbers.size() != 0 || requests_accepted != requests_sent
				|| expected_sums.size() != 0)
			@(negedge clk);
		// watch for a stray strobe over one more full worst-case request
		repeat (23000) @(negedge clk);

		if (mismatch_count == 0)
			$display("aliquot_sum_trial_division_core: match");
		else
			$display("aliquot_sum_trial_division_core: mismatch");
		$finish;
	end

	// watchdog: every request at its slowest, several times over
	initial begin
		#120_000_000;
		$display("aliquot_sum_trial_division_core: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/astd_pkg.sv
hw/rtl/aliquot_sum_trial_division_core.sv
tb/tb_top.sv
